### hw/rtl/irat_pkg.sv
// irat_pkg: shared types, register indexes and operand selection for the
// interleaved region address translator. No dependencies.
package irat_pkg;

    localparam int ADDR_W  = 64;
    localparam int CHUNK_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int DIV_STAGES = ADDR_W;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVE_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVE_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_OFFSET  = 3'd3;

    localparam logic DIR_G2L = 1'b0;
    localparam logic DIR_L2G = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] addr_in;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_out;
        logic              div_error;
    } t_out;

    typedef struct packed {
        logic [ADDR_W-1:0]  region_start;
        logic [CHUNK_W-1:0] interleave_size;
        logic [CHUNK_W-1:0] interleave_step;
        logic [ADDR_W-1:0]  private_offset;
    } t_cfg;

    // per-transaction control: direction, plain-offset mode, zero-divisor error
    typedef struct packed {
        logic dir;
        logic off;
        logic err;
    } t_ctl;

    typedef struct packed {
        t_ctl              ctl;
        logic [ADDR_W-1:0] x;
    } t_job;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_qstat;

    // plain-offset mode divides and multiplies by one
    function automatic logic [CHUNK_W-1:0] div_of(t_ctl c, t_cfg g);
        logic [CHUNK_W-1:0] d;
        if (c.off) begin
            d = CHUNK_W'(1);
        end else if (c.dir == DIR_G2L) begin
            d = g.interleave_step;
        end else begin
            d = g.interleave_size;
        end
        return d;
    endfunction

    function automatic logic [CHUNK_W-1:0] mul_of(t_ctl c, t_cfg g);
        logic [CHUNK_W-1:0] m;
        if (c.off) begin
            m = CHUNK_W'(1);
        end else if (c.dir == DIR_G2L) begin
            m = g.interleave_size;
        end else begin
            m = g.interleave_step;
        end
        return m;
    endfunction

    function automatic logic [ADDR_W-1:0] add_of(t_ctl c, t_cfg g);
        return (c.dir == DIR_G2L) ? g.private_offset : g.region_start;
    endfunction

endpackage

### hw/rtl/irat_front.sv
// irat_front: classifies an incoming transaction and forms the dividend.
// Depends on irat_pkg.
module irat_front (
    input  irat_pkg::t_in  i_in,
    input  irat_pkg::t_cfg i_cfg,
    output irat_pkg::t_job o_job
);
    logic ilv_on;

    always_comb begin
        ilv_on = (i_cfg.interleave_size != '0);
        o_job.ctl.dir = i_in.req_type;
        o_job.ctl.off = !ilv_on;
        o_job.ctl.err = ilv_on && (i_in.req_type == irat_pkg::DIR_G2L)
                        && (i_cfg.interleave_step == '0);
        if (i_in.req_type == irat_pkg::DIR_G2L) begin
            o_job.x = i_in.addr_in - i_cfg.region_start;
        end else begin
            o_job.x = i_in.addr_in - i_cfg.private_offset;
        end
    end
endmodule

### hw/rtl/irat_queue.sv
// irat_queue: small flop FIFO between front and back.
// Depends on irat_pkg.
module irat_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  irat_pkg::t_job        i_job,
    input  logic                  i_pop,
    output irat_pkg::t_job        o_job,
    output irat_pkg::t_qstat      o_stat
);
    irat_pkg::t_job r_mem [irat_pkg::QDEPTH];
    logic [irat_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [irat_pkg::QCNT_W-1:0] r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = (r_cnt == irat_pkg::QCNT_W'(irat_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + irat_pkg::QCNT_W'(i_push) - irat_pkg::QCNT_W'(i_pop);
        end
    end
endmodule

### hw/rtl/irat_back.sv
// irat_back: pipelined restoring divider, split multiply and final sums.
// Depends on irat_pkg.
module irat_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  irat_pkg::t_cfg   i_cfg,
    input  irat_pkg::t_job   i_job,
    input  logic             i_job_avail,
    output logic             o_pop,
    output logic             o_out_valid,
    output irat_pkg::t_out   o_out,
    input  logic             i_out_stall
);
    localparam int N = irat_pkg::DIV_STAGES;
    localparam int AW = irat_pkg::ADDR_W;
    localparam int CW = irat_pkg::CHUNK_W;

    typedef struct packed {
        irat_pkg::t_ctl  ctl;
        logic [CW-1:0]   rem;
        logic [AW-1:0]   dq;
    } t_dstage;

    t_dstage r_s [N+1];
    t_dstage n_s [N];
    logic    r_sv [N+1];

    irat_pkg::t_ctl r_m_ctl, r_a_ctl;
    logic [CW-1:0]  r_m_rem;
    logic [AW-1:0]  r_m_plo;
    logic [CW-1:0]  r_m_phi;
    logic [AW-1:0]  r_a_s1, r_a_s2;
    logic           r_mv, r_av, r_ov;
    irat_pkg::t_out r_out;

    logic en;
    assign en    = !r_ov || !i_out_stall;
    assign o_pop = en && i_job_avail;
    assign o_out_valid = r_ov;
    assign o_out = r_out;

    // one quotient bit per stage
    always_comb begin
        for (int k = 0; k < N; k++) begin
            logic [CW:0]   t, dd;
            logic          ge;
            t  = {r_s[k].rem, r_s[k].dq[AW-1]};
            dd = {1'b0, irat_pkg::div_of(r_s[k].ctl, i_cfg)};
            ge = (t >= dd);
            n_s[k].ctl = r_s[k].ctl;
            n_s[k].rem = ge ? CW'(t - dd) : t[CW-1:0];
            n_s[k].dq  = {r_s[k].dq[AW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) r_sv[k] <= 1'b0;
            r_mv <= 1'b0;
            r_av <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_job_avail;
            for (int k = 0; k < N; k++) r_sv[k+1] <= r_sv[k];
            r_mv <= r_sv[N];
            r_av <= r_mv;
            r_ov <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s[0].ctl <= i_job.ctl;
            r_s[0].rem <= '0;
            r_s[0].dq  <= i_job.x;
            for (int k = 0; k < N; k++) r_s[k+1] <= n_s[k];
            // quotient times multiplier, modulo 2^64, as two 32x32 products
            r_m_ctl <= r_s[N].ctl;
            r_m_rem <= r_s[N].rem;
            r_m_plo <= r_s[N].dq[CW-1:0]  * irat_pkg::mul_of(r_s[N].ctl, i_cfg);
            r_m_phi <= r_s[N].dq[AW-1:CW] * irat_pkg::mul_of(r_s[N].ctl, i_cfg);
            r_a_ctl <= r_m_ctl;
            r_a_s1  <= r_m_plo + {r_m_phi, {CW{1'b0}}};
            r_a_s2  <= irat_pkg::add_of(r_m_ctl, i_cfg) + AW'(r_m_rem);
            r_out.addr_out  <= r_a_ctl.err ? '0 : (r_a_s1 + r_a_s2);
            r_out.div_error <= r_a_ctl.err;
        end
    end
endmodule

### hw/rtl/interleaved_region_address_translate.sv
// interleaved_region_address_translate: top level, config registers,
// front/queue/back wiring. Depends on irat_pkg, irat_front, irat_queue, irat_back.

// Translates one 64-bit address per cycle between the global interleaved
// space and local memory space while i_out_stall is low. Throughput is one
// transaction per clock under the same condition; a transaction passes the
// divider load, 64 restoring-divider stages at one quotient bit each, the
// multiply stage and two add stages. The 64-stage divider sets the latency.
// The four-entry queue decouples input acceptance from output stalls.
// Configuration: write only while idle; index 0 region_start, 1 interleave
// size, 2 interleave step, 3 private offset; other indexes are ignored.
module interleaved_region_address_translate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [irat_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [irat_pkg::ADDR_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  irat_pkg::t_in                     i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output irat_pkg::t_out                    o_out
);
    irat_pkg::t_cfg   r_cfg;
    irat_pkg::t_job   front_job, q_job;
    irat_pkg::t_qstat q_stat;
    logic             push, pop;

    // config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                irat_pkg::REG_REGION_START:    r_cfg.region_start    <= i_cfg_data;
                irat_pkg::REG_INTERLEAVE_SIZE:
                    r_cfg.interleave_size <= i_cfg_data[irat_pkg::CHUNK_W-1:0];
                irat_pkg::REG_INTERLEAVE_STEP:
                    r_cfg.interleave_step <= i_cfg_data[irat_pkg::CHUNK_W-1:0];
                irat_pkg::REG_PRIVATE_OFFSET:  r_cfg.private_offset  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input is taken whenever the queue has room
    assign o_in_stall = q_stat.full;
    assign push       = i_in_valid && !q_stat.full;

    irat_front u_front (
        .i_in  (i_in),
        .i_cfg (r_cfg),
        .o_job (front_job)
    );

    irat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    irat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (q_job),
        .i_job_avail (!q_stat.empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    // error results carry a zero address
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.div_error |-> o_out.addr_out == '0)
        else $error("error result with nonzero address");

    // an error only arises with interleaving on and a zero step
    a_err_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.div_error |->
            r_cfg.interleave_size != '0 && r_cfg.interleave_step == '0)
        else $error("error result without zero step");

    // queue occupancy stays in range
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= irat_pkg::QCNT_W'(irat_pkg::QDEPTH))
        else $error("queue overflow");

    // a pop never comes from an empty queue
    a_q_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");
endmodule
